/* rtl/rud_pkg.sv */
package rud_pkg;

    localparam int COORD_W    = 24;
    localparam int Q_W        = 32;
    localparam int THR_W      = 29;
    localparam int ITER_W     = 7;
    localparam int OUTCOME_W  = 2;
    localparam int STEP_W     = 5;
    localparam int IN_TDATA_W = 48;
    localparam int OUT_TDATA_W = 80;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_X   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FOCAL_Y   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_X  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER_Y  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_K1 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_RADIAL_K2 = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_STOP_THR  = 3'd6;

    localparam logic [OUTCOME_W-1:0] OUT_CONVERGED = 2'd0;
    localparam logic [OUTCOME_W-1:0] OUT_LIMIT     = 2'd1;
    localparam logic [OUTCOME_W-1:0] OUT_SINGULAR  = 2'd2;

    // sequencer positions that leave the multiply sequence
    localparam logic [STEP_W-1:0] STEP_DET   = 5'd20;
    localparam logic [STEP_W-1:0] STEP_SOLVE = 5'd24;

    localparam logic signed [39:0] Q_ONE   = 40'sd268435456;
    localparam logic signed [39:0] S32_MAX = 40'sd2147483647;
    localparam logic signed [39:0] S32_MIN = -40'sd2147483648;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_X0,
        ST_Y0,
        ST_CALC,
        ST_DX,
        ST_DY,
        ST_NORM,
        ST_SQ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic        start;
        logic        neg;
        logic [63:0] num;
        logic [63:0] den;
    } div_req_t;

    typedef struct packed {
        logic               done;
        logic signed [31:0] quot;
    } div_rsp_t;

    function automatic logic signed [39:0] sx40(input logic signed [31:0] a);
        return {{8{a[31]}}, a};
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [39:0] v);
        logic signed [31:0] r;
        if (v > S32_MAX)
            r = 32'sh7fffffff;
        else if (v < S32_MIN)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

    // Q4.28 product: round to nearest, ties up, then saturate
    function automatic logic signed [31:0] qround(input logic signed [63:0] p);
        logic signed [64:0] s;
        logic signed [36:0] sh;
        s  = {p[63], p} + 65'sd134217728;
        sh = s[64:28];
        return sat32({{3{sh[36]}}, sh});
    endfunction

    // sign of a - b in the top bit, magnitude below
    function automatic logic [64:0] sdiff(input logic signed [63:0] a,
                                          input logic signed [63:0] b);
        logic signed [64:0] d;
        logic [64:0]        m;
        d = {a[63], a} - {b[63], b};
        m = d[64] ? (~d + 65'd1) : d;
        return {d[64], m[63:0]};
    endfunction

endpackage

/* rtl/rud_mul.sv */
module rud_mul (
    input  logic               clk,
    input  logic               en,
    input  logic signed [31:0] a,
    input  logic signed [31:0] b,
    output logic signed [63:0] p
);
    logic signed [63:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= a * b;
        end
    end

    assign p = p_reg;
endmodule

/* rtl/rud_div.sv */
module rud_div (
    input  logic               clk,
    input  logic               rst_n,
    input  rud_pkg::div_req_t  req,
    output rud_pkg::div_rsp_t  rsp
);
    import rud_pkg::*;

    logic [63:0] rem_reg;
    logic [63:0] den_reg;
    logic [30:0] low_reg;
    logic [30:0] quo_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic        neg_reg;
    logic        done_reg;
    logic signed [31:0] res_reg;

    logic [64:0] rs;
    logic        ge;
    logic [64:0] rs_sub;
    logic [31:0] qfin;
    logic        ovf;

    assign rs     = {rem_reg, low_reg[30]};
    assign ge     = rs >= {1'b0, den_reg};
    assign rs_sub = rs - {1'b0, den_reg};
    assign qfin   = {1'b0, quo_reg[29:0], ge};
    assign ovf    = {3'b000, req.num} >= {req.den, 3'b000};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= !ovf;
                done_reg <= ovf;
                cnt_reg  <= 5'd31;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg <= req.neg;
            den_reg <= req.den;
            rem_reg <= {3'b000, req.num[63:3]};
            low_reg <= {req.num[2:0], 28'd0};
            if (ovf)
            begin
                res_reg <= req.neg ? 32'sh80000000 : 32'sh7fffffff;
            end
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? rs_sub[63:0] : rs[63:0];
            low_reg <= {low_reg[29:0], 1'b0};
            quo_reg <= {quo_reg[29:0], ge};
            if (cnt_reg == 5'd1)
            begin
                res_reg <= neg_reg ? -qfin : qfin;
            end
        end
    end

    assign rsp.done = done_reg;
    assign rsp.quot = res_reg;
endmodule

/* rtl/radial_undistort_newton.sv */
// Radial lens undistortion (k1, k2) of one distorted pixel by Newton iteration.
// Input stream s_*: one request per pixel, u and v in signed Q16.8.
// Output stream m_*: one result per request: normalized x, y in Q4.28,
// iteration count and outcome (converged, limit, singular Jacobian).
// Configuration: cfg_wr_en, cfg_index, cfg_wdata write one register per cycle;
// write only while no request is in flight.
// One 32x32 multiplier and one restoring divider (one quotient bit per cycle)
// are shared under a sequencer; one request is worked at a time and s_tready
// is low meanwhile.
// The start point takes one setup step (ST_INIT) and two divides; each Newton
// iteration takes 25 sequencer steps, two divides and three update steps
// (ST_NORM, ST_SQ, ST_CHECK), and the result then goes to the output register;
// at most MAX_ITER iterations run, and a divide that saturates ends sooner.
// The result sits in an output register; a new request is taken while it
// waits. If the receiver stalls and a second result is ready, the block
// holds it and stays busy until the output register frees.
// Reset clears the sequencer and the output valid and loads the register
// defaults (unit focal lengths, zero center and coefficients).
module radial_undistort_newton #(
    parameter int MAX_ITER = 16
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // [23:0] u_pixel, [47:24] v_pixel
    input  logic [rud_pkg::IN_TDATA_W-1:0]     s_tdata,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // [31:0] x_norm, [63:32] y_norm, [70:64] iterations_used, [72:71] outcome
    output logic [rud_pkg::OUT_TDATA_W-1:0]    m_tdata,
    input  logic                               cfg_wr_en,
    input  logic [rud_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [rud_pkg::CFG_DATA_W-1:0]     cfg_wdata
);
    import rud_pkg::*;

    state_t state_reg, state_next;
    logic [STEP_W-1:0] step_reg;
    logic [ITER_W-1:0] iter_reg;
    logic              m_valid_reg;

    logic [23:0]        focal_x_reg, focal_y_reg;
    logic signed [23:0] center_x_reg, center_y_reg;
    logic signed [31:0] k1_reg, k2_reg;
    logic [THR_W-1:0]   thr_reg;

    logic signed [23:0] u_reg, v_reg;
    logic [63:0]        thr2_reg;
    logic signed [31:0] x0_reg, y0_reg, x_reg, y_reg;
    logic signed [31:0] x2_reg, y2_reg, r_reg, xy_reg, x4_reg, y4_reg, xy2_reg;
    logic signed [31:0] t_reg, s1_reg, s2_reg, dist_reg, ex_reg, ey_reg;
    logic signed [31:0] j00_reg, j11_reg, j01_reg, dx_reg, dy_reg;
    logic signed [39:0] acc_reg;
    logic signed [63:0] p1_reg;
    logic [63:0]        det_reg, nx_reg, ny_reg;
    logic               sd_reg, sx_reg, sy_reg;
    logic [ITER_W-1:0]  used_reg;
    logic [OUTCOME_W-1:0] outcome_reg;
    logic signed [31:0] xo_reg, yo_reg;
    logic [ITER_W-1:0]  uo_reg;
    logic [OUTCOME_W-1:0] oo_reg;

    logic               mul_en;
    logic signed [31:0] mul_a, mul_b;
    logic signed [63:0] p;
    logic signed [31:0] q;
    div_req_t           div_req;
    div_rsp_t           div_rsp;

    logic [64:0]        dif;
    logic               det_zero, conv, at_limit, out_free, accept;
    logic [ITER_W-1:0]  iter_inc;
    logic signed [24:0] au, av;
    logic [24:0]        mu, mv;
    logic [23:0]        fx_eff, fy_eff;

    rud_mul u_mul (
        .clk (clk),
        .en  (mul_en),
        .a   (mul_a),
        .b   (mul_b),
        .p   (p)
    );

    rud_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    assign q        = qround(p);
    assign dif      = sdiff((state_reg == ST_CALC && step_reg == STEP_DET) ? p : p1_reg,
                            (state_reg == ST_CALC && step_reg == STEP_DET) ? p1_reg : p);
    assign det_zero = dif[63:0] == 64'd0;
    assign conv     = (p1_reg + p) < thr2_reg;
    assign iter_inc = iter_reg + 1'b1;
    assign at_limit = iter_inc == ITER_W'(MAX_ITER);
    assign out_free = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign s_tready = state_reg == ST_IDLE;

    assign au     = {u_reg[23], u_reg} - {center_x_reg[23], center_x_reg};
    assign av     = {v_reg[23], v_reg} - {center_y_reg[23], center_y_reg};
    assign mu     = au[24] ? -au : au;
    assign mv     = av[24] ? -av : av;
    assign fx_eff = (focal_x_reg == 24'd0) ? 24'd1 : focal_x_reg;
    assign fy_eff = (focal_y_reg == 24'd0) ? 24'd1 : focal_y_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (accept) state_next = ST_INIT;
            ST_INIT:  state_next = ST_X0;
            ST_X0:    if (div_rsp.done) state_next = ST_Y0;
            ST_Y0:    if (div_rsp.done) state_next = ST_CALC;
            ST_CALC:
            begin
                if (step_reg == STEP_DET && det_zero)
                    state_next = ST_DONE;
                else if (step_reg == STEP_SOLVE)
                    state_next = ST_DX;
            end
            ST_DX:    if (div_rsp.done) state_next = ST_DY;
            ST_DY:    if (div_rsp.done) state_next = ST_NORM;
            ST_NORM:  state_next = ST_SQ;
            ST_SQ:    state_next = ST_CHECK;
            ST_CHECK: state_next = (conv || at_limit) ? ST_DONE : ST_CALC;
            ST_DONE:  if (out_free) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // multiplier and divider requests
    always_comb
    begin
        mul_en  = 1'b1;
        mul_a   = '0;
        mul_b   = '0;
        div_req = '0;
        case (state_reg)
            ST_INIT:
            begin
                mul_a = {3'b000, thr_reg};
                mul_b = {3'b000, thr_reg};
                div_req.start = 1'b1;
                div_req.neg   = au[24];
                div_req.num   = {39'd0, mu};
                div_req.den   = {40'd0, fx_eff};
            end
            ST_X0:
            begin
                mul_en = 1'b0;
                div_req.start = div_rsp.done;
                div_req.neg   = av[24];
                div_req.num   = {39'd0, mv};
                div_req.den   = {40'd0, fy_eff};
            end
            ST_CALC:
            begin
                case (step_reg)
                    5'd0:  begin mul_a = x_reg;   mul_b = x_reg;    end
                    5'd1:  begin mul_a = y_reg;   mul_b = y_reg;    end
                    5'd2:  begin mul_a = x_reg;   mul_b = y_reg;    end
                    5'd3:  begin mul_a = x2_reg;  mul_b = x2_reg;   end
                    5'd4:  begin mul_a = y2_reg;  mul_b = y2_reg;   end
                    5'd5:  begin mul_a = x2_reg;  mul_b = y2_reg;   end
                    5'd6:  begin mul_a = r_reg;   mul_b = r_reg;    end
                    5'd7:  begin mul_a = k1_reg;  mul_b = r_reg;    end
                    5'd8:  begin mul_a = k2_reg;  mul_b = t_reg;    end
                    5'd9:  begin mul_a = k2_reg;  mul_b = r_reg;    end
                    5'd10: begin mul_a = x_reg;   mul_b = dist_reg; end
                    5'd11: begin mul_a = y_reg;   mul_b = dist_reg; end
                    5'd13: begin mul_a = xy_reg;  mul_b = t_reg;    end
                    5'd14: begin mul_a = k1_reg;  mul_b = s1_reg;   end
                    5'd15: begin mul_a = k2_reg;  mul_b = s1_reg;   end
                    5'd16: begin mul_a = k1_reg;  mul_b = s2_reg;   end
                    5'd17: begin mul_a = k2_reg;  mul_b = s1_reg;   end
                    5'd18: begin mul_a = j01_reg; mul_b = j01_reg;  end
                    5'd19: begin mul_a = j00_reg; mul_b = j11_reg;  end
                    5'd20: begin mul_a = j11_reg; mul_b = ex_reg;   end
                    5'd21: begin mul_a = j01_reg; mul_b = ey_reg;   end
                    5'd22: begin mul_a = j00_reg; mul_b = ey_reg;   end
                    5'd23: begin mul_a = j01_reg; mul_b = ex_reg;   end
                    default: mul_en = 1'b0;
                endcase
                if (step_reg == STEP_SOLVE)
                begin
                    div_req.start = 1'b1;
                    div_req.neg   = sx_reg == sd_reg;
                    div_req.num   = nx_reg;
                    div_req.den   = det_reg;
                end
            end
            ST_DX:
            begin
                mul_en = 1'b0;
                div_req.start = div_rsp.done;
                div_req.neg   = sy_reg == sd_reg;
                div_req.num   = ny_reg;
                div_req.den   = det_reg;
            end
            ST_NORM: begin mul_a = dx_reg; mul_b = dx_reg; end
            ST_SQ:   begin mul_a = dy_reg; mul_b = dy_reg; end
            default: mul_en = 1'b0;
        endcase
    end

    // control state and configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            step_reg     <= '0;
            iter_reg     <= '0;
            m_valid_reg  <= 1'b0;
            focal_x_reg  <= 24'd256;
            focal_y_reg  <= 24'd256;
            center_x_reg <= '0;
            center_y_reg <= '0;
            k1_reg       <= '0;
            k2_reg       <= '0;
            thr_reg      <= 29'd2684;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= (state_reg == ST_CALC && state_next == ST_CALC) ?
                         step_reg + 1'b1 : '0;
            if (state_reg == ST_Y0)
                iter_reg <= '0;
            else if (state_reg == ST_CHECK)
                iter_reg <= iter_inc;
            if (state_reg == ST_DONE && out_free)
                m_valid_reg <= 1'b1;
            else if (m_tready)
                m_valid_reg <= 1'b0;
            if (cfg_wr_en)
            begin
                case (cfg_index)
                    CFG_FOCAL_X:   focal_x_reg  <= cfg_wdata[23:0];
                    CFG_FOCAL_Y:   focal_y_reg  <= cfg_wdata[23:0];
                    CFG_CENTER_X:  center_x_reg <= cfg_wdata[23:0];
                    CFG_CENTER_Y:  center_y_reg <= cfg_wdata[23:0];
                    CFG_RADIAL_K1: k1_reg       <= cfg_wdata;
                    CFG_RADIAL_K2: k2_reg       <= cfg_wdata;
                    CFG_STOP_THR:  thr_reg      <= cfg_wdata[THR_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    u_reg <= s_tdata[23:0];
                    v_reg <= s_tdata[47:24];
                end
            end
            ST_X0:
            begin
                thr2_reg <= p;
                if (div_rsp.done)
                begin
                    x0_reg <= div_rsp.quot;
                    x_reg  <= div_rsp.quot;
                end
            end
            ST_Y0:
            begin
                if (div_rsp.done)
                begin
                    y0_reg <= div_rsp.quot;
                    y_reg  <= div_rsp.quot;
                end
            end
            ST_CALC:
            begin
                case (step_reg)
                    5'd1:  x2_reg <= q;
                    5'd2:
                    begin
                        y2_reg <= q;
                        r_reg  <= sat32(sx40(x2_reg) + sx40(q));
                    end
                    5'd3:  xy_reg  <= q;
                    5'd4:  x4_reg  <= q;
                    5'd5:  y4_reg  <= q;
                    5'd6:  xy2_reg <= q;
                    5'd7:  t_reg   <= q;
                    5'd8:  acc_reg <= Q_ONE + sx40(q);
                    5'd9:  dist_reg <= sat32(acc_reg + sx40(q));
                    5'd10: t_reg   <= q;
                    5'd11: ex_reg  <= sat32(sx40(q) - sx40(x0_reg));
                    5'd12:
                    begin
                        ey_reg <= sat32(sx40(q) - sx40(y0_reg));
                        t_reg  <= sat32((sx40(k1_reg) <<< 1) + (sx40(t_reg) <<< 2));
                        s1_reg <= sat32((sx40(x2_reg) <<< 1) + sx40(x2_reg)
                                        + sx40(y2_reg));
                    end
                    5'd13:
                        s2_reg <= sat32((sx40(y2_reg) <<< 1) + sx40(y2_reg)
                                        + sx40(x2_reg));
                    5'd14:
                    begin
                        j01_reg <= q;
                        s1_reg  <= sat32((sx40(x4_reg) <<< 2) + sx40(x4_reg)
                                         + (sx40(xy2_reg) <<< 2) + (sx40(xy2_reg) <<< 1)
                                         + sx40(y4_reg));
                    end
                    5'd15:
                    begin
                        acc_reg <= Q_ONE + sx40(q);
                        s1_reg  <= sat32((sx40(y4_reg) <<< 2) + sx40(y4_reg)
                                         + (sx40(xy2_reg) <<< 2) + (sx40(xy2_reg) <<< 1)
                                         + sx40(x4_reg));
                    end
                    5'd16: j00_reg <= sat32(acc_reg + sx40(q));
                    5'd17: acc_reg <= Q_ONE + sx40(q);
                    5'd18: j11_reg <= sat32(acc_reg + sx40(q));
                    5'd19: p1_reg  <= p;
                    5'd20:
                    begin
                        sd_reg  <= dif[64];
                        det_reg <= dif[63:0];
                        if (det_zero)
                        begin
                            used_reg    <= iter_reg;
                            outcome_reg <= OUT_SINGULAR;
                        end
                    end
                    5'd21: p1_reg <= p;
                    5'd22:
                    begin
                        sx_reg <= dif[64];
                        nx_reg <= dif[63:0];
                    end
                    5'd23: p1_reg <= p;
                    5'd24:
                    begin
                        sy_reg <= dif[64];
                        ny_reg <= dif[63:0];
                    end
                    default: ;
                endcase
            end
            ST_DX:
            begin
                if (div_rsp.done)
                    dx_reg <= div_rsp.quot;
            end
            ST_DY:
            begin
                if (div_rsp.done)
                    dy_reg <= div_rsp.quot;
            end
            ST_NORM:
            begin
                x_reg <= sat32(sx40(x_reg) + sx40(dx_reg));
                y_reg <= sat32(sx40(y_reg) + sx40(dy_reg));
            end
            ST_SQ:
                p1_reg <= p;
            ST_CHECK:
            begin
                if (conv)
                begin
                    used_reg    <= iter_inc;
                    outcome_reg <= OUT_CONVERGED;
                end
                else
                begin
                    used_reg    <= ITER_W'(MAX_ITER);
                    outcome_reg <= OUT_LIMIT;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    xo_reg <= x_reg;
                    yo_reg <= y_reg;
                    uo_reg <= used_reg;
                    oo_reg <= outcome_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {7'd0, oo_reg, uo_reg, yo_reg, xo_reg};
endmodule

/* rtl/rud_checker.sv */
module rud_checker #(
    parameter int MAX_ITER = 16
) (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [rud_pkg::OUT_TDATA_W-1:0] m_tdata
);
    import rud_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("result dropped while stalled");

    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("result changed while stalled");

    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

    a_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[72:71] <= OUT_SINGULAR)
                     && (m_tdata[70:64] <= ITER_W'(MAX_ITER)))
        else $error("result fields out of range");
endmodule

bind radial_undistort_newton rud_checker #(.MAX_ITER(MAX_ITER)) u_rud_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
